>>> rtl/cwbl_pkg.sv
// Shared types and constants of the channel write budget limiter.
// Holds the beat payload structs, command and level codes, and register indexes.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package cwbl_pkg;

   localparam int CHAN_W  = 4;
   localparam int BLOCK_W = 10;
   localparam int COUNT_W = 16;
   localparam int TOTAL_W = 20;
   localparam int INDEX_W = 2;
   localparam int PROD_W  = 2 * COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic [COUNT_W-1:0] BUDGET_RESET  = 16'd512;
   localparam logic [COUNT_W-1:0] HIGH_RESET    = 16'd1024;
   localparam logic [COUNT_W-1:0] RESERVE_RESET = 16'd64;

   localparam logic [INDEX_W-1:0] CSR_BUDGET  = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_HIGH    = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_RESERVE = 2'd2;

   typedef enum logic [1:0] {
      CMD_ADD           = 2'd0,
      CMD_REMOVE_USED   = 2'd1,
      CMD_REMOVE_UNUSED = 2'd2,
      CMD_REFRESH       = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      LEVEL_NONE = 2'd0,
      LEVEL_HIGH = 2'd1,
      LEVEL_MID  = 2'd2,
      LEVEL_LOW  = 2'd3
   } level_type;

   typedef struct packed {
      command_type        command;
      logic [CHAN_W-1:0]  channel;
      logic [BLOCK_W-1:0] block_count;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel_out;
      logic [COUNT_W-1:0] free_total;
      logic [COUNT_W-1:0] free_user;
      logic [COUNT_W-1:0] user_share;
      logic [TOTAL_W-1:0] user_budget_total;
      logic [TOTAL_W-1:0] gc_budget_total;
      level_type          level;
      logic               gc_start;
      logic               gc_stop;
   } rsp_type;

   // One row of the per-channel state memory.
   typedef struct packed {
      logic [COUNT_W-1:0] free_total;
      logic [COUNT_W-1:0] free_user;
      logic [COUNT_W-1:0] share;
      level_type          level;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/cwbl_div.sv
// Radix-2 restoring divider for the mid-band share, one quotient bit per cycle.
// Assumes the dividend's upper half is below the divisor, so the quotient fits COUNT_W bits.
// Depends on cwbl_pkg for widths.
`default_nettype none

module cwbl_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [cwbl_pkg::PROD_W-1:0]  dividend,
   input  wire logic [cwbl_pkg::COUNT_W-1:0] divisor,
   output logic                             done,
   output logic [cwbl_pkg::COUNT_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(cwbl_pkg::COUNT_W);

   logic [cwbl_pkg::COUNT_W-1:0] rem_ff;
   logic [cwbl_pkg::COUNT_W-1:0] quo_ff;
   logic [cwbl_pkg::COUNT_W-1:0] div_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         busy_ff;
   logic                         done_ff;

   logic [cwbl_pkg::COUNT_W:0]   shifted;
   logic [cwbl_pkg::COUNT_W:0]   diff;
   logic                         qbit;

   always_comb begin
      shifted = {rem_ff, quo_ff[cwbl_pkg::COUNT_W-1]};
      diff    = shifted - {1'b0, div_ff};
      qbit    = (shifted >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // Done pulses for one cycle after the last quotient bit is shifted in.
         done_ff <= busy_ff && !start && (cnt_ff == '0);
         if (start) begin
            rem_ff  <= dividend[cwbl_pkg::PROD_W-1:cwbl_pkg::COUNT_W];
            quo_ff  <= dividend[cwbl_pkg::COUNT_W-1:0];
            div_ff  <= divisor;
            cnt_ff  <= '1;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= qbit ? diff[cwbl_pkg::COUNT_W-1:0] : shifted[cwbl_pkg::COUNT_W-1:0];
            quo_ff <= {quo_ff[cwbl_pkg::COUNT_W-2:0], qbit};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/channel_write_budget_limiter_unit.sv
// Per-channel write budget limiter: a request goes through read, classify and finish
// when the channel ends at or above the high mark or at/below the reserve, adds the
// divide state in the mid band, and skips to finish for a channel at or beyond NCH.
// One item is in flight at a time; a new request is taken only once the last response is
// registered and the unit is back in idle. Reset is synchronous; counts, shares, levels
// clear at once via per-entry valid bits; the user sum clears; registers go to defaults.
`default_nettype none

module channel_write_budget_limiter_unit #(
   parameter int NCH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire cwbl_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output cwbl_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [cwbl_pkg::INDEX_W-1:0] csr_index,
   input  wire logic [cwbl_pkg::COUNT_W-1:0] csr_data
);

   localparam int DEPTH  = (NCH < 16) ? NCH : 16;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = cwbl_pkg::COUNT_W + $clog2(NCH + 1);
   localparam int ALL_W  = (PROD_W > cwbl_pkg::TOTAL_W) ? PROD_W : cwbl_pkg::TOTAL_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CLASS,
      S_DIV,
      S_FINISH
   } state_type;

   state_type                    state_ff;
   cwbl_pkg::req_type            item_ff;
   logic                         in_range_ff;
   logic                         old_valid_ff;
   logic [DEPTH-1:0]             entry_valid_ff;
   cwbl_pkg::entry_type          mem [DEPTH];
   cwbl_pkg::entry_type          rd_ff;
   logic [cwbl_pkg::COUNT_W-1:0] budget_ff;
   logic [cwbl_pkg::COUNT_W-1:0] high_ff;
   logic [cwbl_pkg::COUNT_W-1:0] reserve_ff;
   logic [cwbl_pkg::COUNT_W-1:0] free_total_ff;
   logic [cwbl_pkg::COUNT_W-1:0] free_user_ff;
   logic [cwbl_pkg::COUNT_W-1:0] old_share_ff;
   cwbl_pkg::level_type          old_level_ff;
   logic [cwbl_pkg::COUNT_W-1:0] share_ff;
   cwbl_pkg::level_type          level_ff;
   logic [cwbl_pkg::TOTAL_W-1:0] user_sum_ff;
   logic                         rsp_valid_ff;
   cwbl_pkg::rsp_type            rsp_data_ff;

   logic                         req_fire;
   logic                         req_in_range;
   logic [AW-1:0]                req_addr;
   logic [AW-1:0]                item_addr;
   cwbl_pkg::entry_type          old_entry;
   logic [cwbl_pkg::COUNT_W:0]   ft_add;
   logic [cwbl_pkg::COUNT_W:0]   fu_add;
   logic [cwbl_pkg::COUNT_W-1:0] ft_sub;
   logic [cwbl_pkg::COUNT_W-1:0] fu_sub;
   logic [cwbl_pkg::COUNT_W-1:0] ft_in;
   logic [cwbl_pkg::COUNT_W-1:0] fu_in;
   logic                         cls_high;
   logic                         cls_mid;
   logic                         div_start;
   logic [cwbl_pkg::PROD_W-1:0]  div_dividend;
   logic [cwbl_pkg::COUNT_W-1:0] div_divisor;
   logic                         div_done;
   logic [cwbl_pkg::COUNT_W-1:0] div_quotient;
   logic                         out_free;
   logic [cwbl_pkg::TOTAL_W-1:0] sum_in;
   logic [ALL_W-1:0]             all_budget;
   logic [ALL_W-1:0]             gc_wide;
   logic [cwbl_pkg::TOTAL_W-1:0] gc_in;
   cwbl_pkg::rsp_type            rsp_in;
   cwbl_pkg::entry_type          entry_new;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_in_range = (32'(req_data.channel) < NCH);
   assign req_addr     = req_data.channel[AW-1:0];
   assign item_addr    = item_ff.channel[AW-1:0];

   // A channel never written since reset reads as all zero.
   assign old_entry = old_valid_ff ? rd_ff : '0;

   always_comb begin
      ft_add = {1'b0, old_entry.free_total} + (cwbl_pkg::COUNT_W + 1)'(item_ff.block_count);
      fu_add = {1'b0, old_entry.free_user} + (cwbl_pkg::COUNT_W + 1)'(item_ff.block_count);
      ft_sub = (old_entry.free_total > cwbl_pkg::COUNT_W'(item_ff.block_count)) ?
               old_entry.free_total - cwbl_pkg::COUNT_W'(item_ff.block_count) : '0;
      fu_sub = (old_entry.free_user > cwbl_pkg::COUNT_W'(item_ff.block_count)) ?
               old_entry.free_user - cwbl_pkg::COUNT_W'(item_ff.block_count) : '0;
      ft_in  = old_entry.free_total;
      fu_in  = old_entry.free_user;
      case (item_ff.command)
         cwbl_pkg::CMD_ADD: begin
            ft_in = ft_add[cwbl_pkg::COUNT_W] ? cwbl_pkg::COUNT_MAX : ft_add[cwbl_pkg::COUNT_W-1:0];
            fu_in = fu_add[cwbl_pkg::COUNT_W] ? cwbl_pkg::COUNT_MAX : fu_add[cwbl_pkg::COUNT_W-1:0];
         end
         cwbl_pkg::CMD_REMOVE_USED: begin
            ft_in = ft_sub;
            fu_in = fu_sub;
         end
         cwbl_pkg::CMD_REMOVE_UNUSED: begin
            ft_in = ft_sub;
         end
         cwbl_pkg::CMD_REFRESH: begin
            ft_in = old_entry.free_total;
         end
         default: begin
            ft_in = old_entry.free_total;
         end
      endcase
   end

   // The high test wins when the marks are out of order, so the mid band never
   // sees a zero divisor.
   assign cls_high     = (free_user_ff >= high_ff);
   assign cls_mid      = !cls_high && (free_user_ff > reserve_ff);
   assign div_start    = (state_ff == S_CLASS) && cls_mid;
   assign div_dividend = cwbl_pkg::PROD_W'(budget_ff) *
                         cwbl_pkg::PROD_W'(free_user_ff - reserve_ff);
   assign div_divisor  = high_ff - reserve_ff;

   cwbl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sum_in = in_range_ff ?
               user_sum_ff - cwbl_pkg::TOTAL_W'(old_share_ff) + cwbl_pkg::TOTAL_W'(share_ff) :
               user_sum_ff;
      all_budget = ALL_W'(budget_ff) * ALL_W'(NCH);
      gc_wide    = (all_budget > ALL_W'(sum_in)) ? all_budget - ALL_W'(sum_in) : '0;
      gc_in      = (gc_wide > ALL_W'(cwbl_pkg::TOTAL_MAX)) ? cwbl_pkg::TOTAL_MAX :
                   gc_wide[cwbl_pkg::TOTAL_W-1:0];

      rsp_in.channel_out       = item_ff.channel;
      rsp_in.user_budget_total = sum_in;
      rsp_in.gc_budget_total   = gc_in;
      if (in_range_ff) begin
         rsp_in.free_total = free_total_ff;
         rsp_in.free_user  = free_user_ff;
         rsp_in.user_share = share_ff;
         rsp_in.level      = level_ff;
         rsp_in.gc_start   = (level_ff != cwbl_pkg::LEVEL_HIGH);
         rsp_in.gc_stop    = (level_ff == cwbl_pkg::LEVEL_HIGH) &&
                             (old_level_ff != cwbl_pkg::LEVEL_HIGH);
      end else begin
         rsp_in.free_total = '0;
         rsp_in.free_user  = '0;
         rsp_in.user_share = '0;
         rsp_in.level      = cwbl_pkg::LEVEL_LOW;
         rsp_in.gc_start   = 1'b0;
         rsp_in.gc_stop    = 1'b0;
      end

      entry_new.free_total = free_total_ff;
      entry_new.free_user  = free_user_ff;
      entry_new.share      = share_ff;
      entry_new.level      = level_ff;
   end

   // State memory: read on request acceptance, written back when the response is loaded.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= mem[req_addr];
      end
      if ((state_ff == S_FINISH) && out_free && in_range_ff) begin
         mem[item_addr] <= entry_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         user_sum_ff    <= '0;
         entry_valid_ff <= '0;
         budget_ff      <= cwbl_pkg::BUDGET_RESET;
         high_ff        <= cwbl_pkg::HIGH_RESET;
         reserve_ff     <= cwbl_pkg::RESERVE_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cwbl_pkg::CSR_BUDGET:  budget_ff  <= csr_data;
               cwbl_pkg::CSR_HIGH:    high_ff    <= csr_data;
               cwbl_pkg::CSR_RESERVE: reserve_ff <= csr_data;
               default: ;
            endcase
         end

         // In the finish state a drained beat is replaced by the new one below.
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff      <= req_data;
                  in_range_ff  <= req_in_range;
                  old_valid_ff <= entry_valid_ff[req_addr];
                  state_ff     <= req_in_range ? S_READ : S_FINISH;
               end
            end
            S_READ: begin
               free_total_ff <= ft_in;
               free_user_ff  <= fu_in;
               old_share_ff  <= old_entry.share;
               old_level_ff  <= old_entry.level;
               state_ff      <= S_CLASS;
            end
            S_CLASS: begin
               if (cls_high) begin
                  level_ff <= cwbl_pkg::LEVEL_HIGH;
                  share_ff <= budget_ff;
                  state_ff <= S_FINISH;
               end else if (cls_mid) begin
                  level_ff <= cwbl_pkg::LEVEL_MID;
                  state_ff <= S_DIV;
               end else begin
                  level_ff <= cwbl_pkg::LEVEL_LOW;
                  share_ff <= '0;
                  state_ff <= S_FINISH;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  share_ff <= div_quotient;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_in;
                  user_sum_ff  <= sum_in;
                  if (in_range_ff) begin
                     entry_valid_ff[item_addr] <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/cwbl_checker.sv
// Port-level checks of the channel write budget limiter, bound to the top level.
// Depends on cwbl_pkg for payload types and level codes.
`default_nettype none

module cwbl_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire cwbl_pkg::rsp_type            rsp_data
);

   // A response beat that is stalled holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // GC start follows a mid or low level of an in-range channel; stop only on high.
   a_stop_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.gc_stop |->
         rsp_data.level == cwbl_pkg::LEVEL_HIGH && !rsp_data.gc_start)
      else $error("gc_stop raised outside the high level");

   a_low_share: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.level == cwbl_pkg::LEVEL_LOW |-> rsp_data.user_share == '0)
      else $error("low-level channel reported a nonzero share");

   a_mid_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.level == cwbl_pkg::LEVEL_MID |-> rsp_data.gc_start)
      else $error("mid-level channel did not request gc start");

   // No response is pending right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind channel_write_budget_limiter_unit cwbl_checker u_checker (.*);

`default_nettype wire
